// ----- rtl/core/lmrsd_pkg.sv -----
// package for the led matrix row scan dimmer
// field widths, op codes and the per-tick metadata struct; no dependencies
package lmrsd_pkg;

    localparam int ROWS_DEFAULT       = 11;
    localparam int DIM_PERIOD_DEFAULT = 10;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 4;
    localparam int WORD_W     = 16;
    localparam int BRIGHT_W   = 4;
    localparam int DIM_W      = 4;
    localparam int COL_W      = 11;
    localparam int ROWEN_W    = 11;
    localparam int COL_SHIFT  = 5;
    localparam int CMP_W      = 6;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        logic               lit;
        logic               entry_vld;
        logic [ROWEN_W-1:0] row_enable;
    } tick_meta_t;

endpackage

// ----- rtl/core/lmrsd_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module lmrsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 11
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/lmrsd_scan.sv -----
// scan control: brightness register, row and dimming counters, entry valid bits
// drives the frame store ram ports; uses lmrsd_pkg
module lmrsd_scan #(
    parameter int ROWS       = lmrsd_pkg::ROWS_DEFAULT,
    parameter int DIM_PERIOD = lmrsd_pkg::DIM_PERIOD_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_fire,
    input  logic [lmrsd_pkg::OP_W-1:0]      op,
    input  logic [lmrsd_pkg::IDX_W-1:0]     row_index,
    input  logic [lmrsd_pkg::WORD_W-1:0]    row_word,
    input  logic                            cfg_we,
    input  logic [lmrsd_pkg::BRIGHT_W-1:0]  cfg_wdata,
    output logic                            tick,
    output logic                            ram_wr_en,
    output logic [$clog2(ROWS)-1:0]         ram_wr_addr,
    output logic [lmrsd_pkg::WORD_W-1:0]    ram_wr_data,
    output logic                            ram_rd_en,
    output logic [$clog2(ROWS)-1:0]         ram_rd_addr,
    output lmrsd_pkg::tick_meta_t           meta
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int DIM_W = lmrsd_pkg::DIM_W;
    localparam int CMP_W = lmrsd_pkg::CMP_W;

    logic [lmrsd_pkg::BRIGHT_W-1:0] brightness_reg;
    logic [ROW_W-1:0]               scan_row_reg;
    logic [ROW_W-1:0]               scan_row_next;
    logic [DIM_W-1:0]               dim_count_reg;
    logic [DIM_W-1:0]               dim_count_next;
    logic [ROWS-1:0]                entry_vld_reg;
    logic [ROWS-1:0]                entry_vld_next;
    lmrsd_pkg::tick_meta_t          meta_reg;
    lmrsd_pkg::tick_meta_t          meta_next;

    lmrsd_pkg::op_t                 op_code;
    logic                           is_write;
    logic                           is_clear;
    logic [CMP_W-1:0]               idx_ext;
    logic                           wr_ok;
    logic [ROW_W:0]                 row_inc;
    logic [ROW_W-1:0]               row_step;
    logic [DIM_W-1:0]               dim_dec;
    logic                           lit;
    logic [lmrsd_pkg::ROWEN_W-1:0]  row_en;

    always_comb
    begin
        op_code  = lmrsd_pkg::op_t'(op);
        tick     = 1'b0;
        is_write = 1'b0;
        is_clear = 1'b0;
        unique case (op_code)
            lmrsd_pkg::OP_TICK:  tick     = in_fire;
            lmrsd_pkg::OP_WRITE: is_write = in_fire;
            lmrsd_pkg::OP_CLEAR: is_clear = in_fire;
            default: ;
        endcase
    end

    // row write, ignored when the index is past the last row
    assign idx_ext     = CMP_W'(row_index);
    assign wr_ok       = is_write && (idx_ext < CMP_W'(ROWS));
    assign ram_wr_en   = wr_ok;
    assign ram_wr_addr = idx_ext[ROW_W-1:0];
    assign ram_wr_data = row_word;

    // row counter wraps at the last row
    assign row_inc  = {1'b0, scan_row_reg} + (ROW_W+1)'(1);
    assign row_step = (row_inc >= (ROW_W+1)'(ROWS)) ? '0 : row_inc[ROW_W-1:0];

    // dimming counter, decrement saturates at zero
    assign dim_dec = (dim_count_reg == '0) ? '0 : dim_count_reg - DIM_W'(1);
    assign lit     = (dim_dec <= brightness_reg);

    always_comb
    begin
        for (int i = 0; i < lmrsd_pkg::ROWEN_W; i++)
        begin
            row_en[i] = (CMP_W'(row_step) == CMP_W'(i));
        end
    end

    assign ram_rd_en   = tick;
    assign ram_rd_addr = row_step;

    always_comb
    begin
        scan_row_next  = scan_row_reg;
        dim_count_next = dim_count_reg;
        meta_next      = meta_reg;
        if (tick)
        begin
            scan_row_next        = row_step;
            dim_count_next       = lit ? DIM_W'(DIM_PERIOD) : dim_dec;
            meta_next.lit        = lit;
            meta_next.entry_vld  = entry_vld_reg[row_step];
            meta_next.row_enable = row_en;
        end
    end

    always_comb
    begin
        entry_vld_next = entry_vld_reg;
        for (int i = 0; i < ROWS; i++)
        begin
            if (is_clear)
            begin
                entry_vld_next[i] = 1'b0;
            end
            else if (wr_ok && (ram_wr_addr == ROW_W'(i)))
            begin
                entry_vld_next[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= '0;
            scan_row_reg   <= '0;
            dim_count_reg  <= DIM_W'(DIM_PERIOD);
            entry_vld_reg  <= '0;
            meta_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                brightness_reg <= cfg_wdata;
            end
            scan_row_reg  <= scan_row_next;
            dim_count_reg <= dim_count_next;
            entry_vld_reg <= entry_vld_next;
            meta_reg      <= meta_next;
        end
    end

    assign meta = meta_reg;

endmodule

// ----- rtl/core/lmrsd_drive.sv -----
// output register: masks the row word read from the frame store into column levels
// and holds the result until the receiver takes it; uses lmrsd_pkg
module lmrsd_drive (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rd_vld,
    input  lmrsd_pkg::tick_meta_t              meta,
    input  logic [lmrsd_pkg::WORD_W-1:0]       rd_data,
    output logic                               rd_take,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lmrsd_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                               m_tuser
);

    localparam int COL_W   = lmrsd_pkg::COL_W;
    localparam int ROWEN_W = lmrsd_pkg::ROWEN_W;
    localparam int PAD_W   = lmrsd_pkg::OUT_DATA_W - COL_W - ROWEN_W;

    logic               out_vld_reg;
    logic               out_vld_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROWEN_W-1:0] ren_reg;
    logic [ROWEN_W-1:0] ren_next;
    logic               lit_reg;
    logic               lit_next;

    assign rd_take = rd_vld && (!out_vld_reg || m_tready);

    always_comb
    begin
        out_vld_next = out_vld_reg;
        col_next     = col_reg;
        ren_next     = ren_reg;
        lit_next     = lit_reg;
        if (rd_take)
        begin
            out_vld_next = 1'b1;
            lit_next     = meta.lit;
            col_next     = (meta.lit && meta.entry_vld)
                         ? rd_data[lmrsd_pkg::COL_SHIFT +: COL_W] : '0;
            ren_next     = meta.lit ? meta.row_enable : '0;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        ren_reg <= ren_next;
        lit_reg <= lit_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, ren_reg, col_reg};
    assign m_tuser  = lit_reg;

endmodule

// ----- rtl/core/led_matrix_row_scan_dimmer.sv -----
// top level of the led matrix row scan dimmer
// uses lmrsd_pkg, lmrsd_scan, lmrsd_ram and lmrsd_drive
//
// input stream s_*: tuser carries the op (tick, write row word, clear frame store),
// tdata carries the row index and the 16-bit row word. a write loads one row of
// the frame store, a clear empties it; neither gives a result. every tick steps
// the row counter and the dimming counter and gives exactly one output transfer.
// output stream m_*: tdata carries the 11 column levels and the one-hot row enable,
// tuser flags a lit tick; a blank tick carries zeros.
// brightness is written through cfg_we / cfg_wdata by the user only while the
// block is idle; the block itself does not enforce this. one item is taken per cycle
// unless stalled. a tick reads the frame store ram, then fills the output register.
// when the receiver stalls, the output register holds the result and the read
// stage behind it holds one more tick; further input waits with s_tready low.
// reset empties the frame store at once through per-row valid bits, sets the
// row counter to the first row, the dimming counter to its period and
// brightness to zero; no clearing pass is needed.
module led_matrix_row_scan_dimmer #(
    parameter int ROWS       = lmrsd_pkg::ROWS_DEFAULT,
    parameter int DIM_PERIOD = lmrsd_pkg::DIM_PERIOD_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lmrsd_pkg::IN_DATA_W-1:0]     s_tdata,   // row_index, row_word, zero pad
    input  logic [lmrsd_pkg::OP_W-1:0]          s_tuser,   // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lmrsd_pkg::OUT_DATA_W-1:0]    m_tdata,   // column_drive, row_enable, zero pad
    output logic                                m_tuser,   // lit
    input  logic                                cfg_we,
    input  logic [lmrsd_pkg::BRIGHT_W-1:0]      cfg_wdata
);

    localparam int ROW_W  = $clog2(ROWS);
    localparam int IDX_W  = lmrsd_pkg::IDX_W;
    localparam int WORD_W = lmrsd_pkg::WORD_W;

    logic                  in_fire;
    logic                  tick;
    logic                  ram_wr_en;
    logic [ROW_W-1:0]      ram_wr_addr;
    logic [WORD_W-1:0]     ram_wr_data;
    logic                  ram_rd_en;
    logic [ROW_W-1:0]      ram_rd_addr;
    logic [WORD_W-1:0]     ram_rd_data;
    lmrsd_pkg::tick_meta_t meta;
    logic                  rd_vld_reg;
    logic                  rd_vld_next;
    logic                  rd_take;

    assign s_tready = !rd_vld_reg || rd_take;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        rd_vld_next = rd_vld_reg;
        if (tick)
        begin
            rd_vld_next = 1'b1;
        end
        else if (rd_take)
        begin
            rd_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_vld_next;
        end
    end

    lmrsd_scan #(
        .ROWS       (ROWS),
        .DIM_PERIOD (DIM_PERIOD)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .op          (s_tuser),
        .row_index   (s_tdata[IDX_W-1:0]),
        .row_word    (s_tdata[IDX_W +: WORD_W]),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .tick        (tick),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .meta        (meta)
    );

    lmrsd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lmrsd_drive u_drive (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_vld   (rd_vld_reg),
        .meta     (meta),
        .rd_data  (ram_rd_data),
        .rd_take  (rd_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
